/* rtl/rubn_pkg.sv */
// shared types and constants for the rotate and unit-box normalise block
// no dependencies; used by rubn_rot, rubn_div and the top level
package rubn_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_FRAC_DEF  = 16;
    localparam int TRIG_FRAC_DEF   = 14;
    localparam int TRIG_WIDTH      = 16;
    localparam int CMD_WIDTH       = 2;

    localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET = 16'sd0;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_MEASURE   = 2'd1,
        CMD_NORMALIZE = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_COS = 1'b0,
        REG_SIN = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        ROT_IDLE,
        ROT_CX,
        ROT_SY,
        ROT_SX,
        ROT_CY,
        ROT_FIN
    } rot_st_t;

endpackage

/* rtl/rotate_and_unit_box_normalize_unit.sv */
// top level: rotate about z, min/max box keeping and per-axis normalise
// depends on rubn_pkg, rubn_rot, rubn_div
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata = x_in, y_in, z_in; s_tuser = cmd
// m_        out  m_tvalid/m_tready  m_tdata = x_norm, y_norm, z_norm; m_tuser = degenerate
// cfg_      in   cfg_we             cfg_index, cfg_data (0 cos_angle, 1 sin_angle)
//
// clear and the unused command are handled in the idle state; measure rotates the point, then widens the box.
// normalise divides one axis at a time on the shared divider, one quotient bit per cycle.
// a zero extent skips its division; an empty box skips all three.
// reset leaves the box empty and the angle at zero; there is no clearing pass.
// a result waiting on m_tready does not block new transfers in; the next result
// waits for the output register to free.
module rotate_and_unit_box_normalize_unit #(
    parameter int COORD_WIDTH = rubn_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC  = rubn_pkg::COORD_FRAC_DEF,
    parameter int TRIG_FRAC   = rubn_pkg::TRIG_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_in, y_in, z_in
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // cmd
    input  logic [rubn_pkg::CMD_WIDTH-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // x_norm, y_norm, z_norm
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // degenerate
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [rubn_pkg::TRIG_WIDTH-1:0]     cfg_data
);

    localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    rubn_pkg::state_t state_reg, state_next;
    rubn_pkg::axis_t  axis_reg, axis_next;
    rubn_pkg::cmd_t   cmd_reg, cmd_next;
    rubn_pkg::cmd_t   cmd_in;

    logic signed [rubn_pkg::TRIG_WIDTH-1:0] cos_reg, cos_next;
    logic signed [rubn_pkg::TRIG_WIDTH-1:0] sin_reg, sin_next;
    logic signed [COORD_WIDTH-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [COORD_WIDTH-1:0] min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic signed [COORD_WIDTH-1:0] min_z_reg, min_z_next, max_x_reg, max_x_next;
    logic signed [COORD_WIDTH-1:0] max_y_reg, max_y_next, max_z_reg, max_z_next;
    logic signed [COORD_WIDTH-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic signed [COORD_WIDTH-1:0] res_z_reg, res_z_next;
    logic                          deg_reg, deg_next;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic signed [COORD_WIDTH-1:0] out_z_reg, out_z_next;
    logic                          out_deg_reg, out_deg_next;
    logic                          m_valid_reg, m_valid_next;

    logic                          rot_start, rot_done;
    logic signed [COORD_WIDTH-1:0] rx, ry;
    logic                          div_start, div_done;
    logic signed [COORD_WIDTH-1:0] div_quot;
    logic signed [COORD_WIDTH-1:0] p_sel, mn_sel, mx_sel;
    logic signed [COORD_WIDTH:0]   numer;
    logic signed [COORD_WIDTH:0]   extent;
    logic                          ext_zero;
    logic                          box_empty;
    logic                          last_axis;
    logic                          axis_write;
    logic signed [COORD_WIDTH-1:0] axis_val;

    rubn_rot #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_FRAC   (TRIG_FRAC)
    ) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rot_start),
        .cos_angle (cos_reg),
        .sin_angle (sin_reg),
        .x         (x_reg),
        .y         (y_reg),
        .done      (rot_done),
        .rx        (rx),
        .ry        (ry)
    );

    rubn_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .COORD_FRAC  (COORD_FRAC)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (extent[COORD_WIDTH-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rubn_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            cos_reg     <= rubn_pkg::COS_RESET;
            sin_reg     <= rubn_pkg::SIN_RESET;
            min_x_reg   <= CMAX;
            min_y_reg   <= CMAX;
            min_z_reg   <= CMAX;
            max_x_reg   <= CMIN;
            max_y_reg   <= CMIN;
            max_z_reg   <= CMIN;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            min_x_reg   <= min_x_next;
            min_y_reg   <= min_y_next;
            min_z_reg   <= min_z_next;
            max_x_reg   <= max_x_next;
            max_y_reg   <= max_y_next;
            max_z_reg   <= max_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg    <= axis_next;
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_z_reg   <= res_z_next;
        deg_reg     <= deg_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_z_reg   <= out_z_next;
        out_deg_reg <= out_deg_next;
    end

    // operands of the axis under division
    always_comb
    begin
        case (axis_reg)
            rubn_pkg::AX_X:
            begin
                p_sel  = rx;
                mn_sel = min_x_reg;
                mx_sel = max_x_reg;
            end
            rubn_pkg::AX_Y:
            begin
                p_sel  = ry;
                mn_sel = min_y_reg;
                mx_sel = max_y_reg;
            end
            rubn_pkg::AX_Z:
            begin
                p_sel  = z_reg;
                mn_sel = min_z_reg;
                mx_sel = max_z_reg;
            end
            default:
            begin
                p_sel  = '0;
                mn_sel = '0;
                mx_sel = '0;
            end
        endcase
        numer     = {p_sel[COORD_WIDTH-1], p_sel} - {mn_sel[COORD_WIDTH-1], mn_sel};
        extent    = {mx_sel[COORD_WIDTH-1], mx_sel} - {mn_sel[COORD_WIDTH-1], mn_sel};
        ext_zero  = (mx_sel == mn_sel);
        box_empty = (min_x_reg > max_x_reg);
        last_axis = (axis_reg == rubn_pkg::AX_Z);
    end

    always_comb
    begin
        cmd_in       = rubn_pkg::cmd_t'(s_tuser);
        state_next   = state_reg;
        axis_next    = axis_reg;
        cmd_next     = cmd_reg;
        cos_next     = cos_reg;
        sin_next     = sin_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        min_x_next   = min_x_reg;
        min_y_next   = min_y_reg;
        min_z_next   = min_z_reg;
        max_x_next   = max_x_reg;
        max_y_next   = max_y_reg;
        max_z_next   = max_z_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        res_z_next   = res_z_reg;
        deg_next     = deg_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        out_deg_next = out_deg_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rot_start    = 1'b0;
        div_start    = 1'b0;
        axis_write   = 1'b0;
        axis_val     = '0;
        s_tready     = (state_reg == rubn_pkg::ST_IDLE);

        if (cfg_we)
        begin
            case (rubn_pkg::reg_idx_t'(cfg_index))
                rubn_pkg::REG_COS: cos_next = cfg_data;
                rubn_pkg::REG_SIN: sin_next = cfg_data;
                default:           cos_next = cos_reg;
            endcase
        end

        case (state_reg)
            rubn_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next   = s_tdata[COORD_WIDTH-1:0];
                    y_next   = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                    z_next   = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
                    cmd_next = cmd_in;
                    case (cmd_in)
                        rubn_pkg::CMD_CLEAR:
                        begin
                            min_x_next = CMAX;
                            min_y_next = CMAX;
                            min_z_next = CMAX;
                            max_x_next = CMIN;
                            max_y_next = CMIN;
                            max_z_next = CMIN;
                        end
                        rubn_pkg::CMD_MEASURE, rubn_pkg::CMD_NORMALIZE:
                        begin
                            rot_start  = 1'b1;
                            state_next = rubn_pkg::ST_ROT;
                        end
                        default:
                        begin
                            state_next = rubn_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rubn_pkg::ST_ROT:
            begin
                if (rot_done)
                begin
                    state_next = rubn_pkg::ST_CHECK;
                end
            end
            rubn_pkg::ST_CHECK:
            begin
                if (cmd_reg == rubn_pkg::CMD_MEASURE)
                begin
                    if (rx < min_x_reg) min_x_next = rx;
                    if (ry < min_y_reg) min_y_next = ry;
                    if (z_reg < min_z_reg) min_z_next = z_reg;
                    if (rx > max_x_reg) max_x_next = rx;
                    if (ry > max_y_reg) max_y_next = ry;
                    if (z_reg > max_z_reg) max_z_next = z_reg;
                    state_next = rubn_pkg::ST_IDLE;
                end
                else
                begin
                    res_x_next = '0;
                    res_y_next = '0;
                    res_z_next = '0;
                    deg_next   = box_empty;
                    axis_next  = rubn_pkg::AX_X;
                    state_next = box_empty ? rubn_pkg::ST_DONE : rubn_pkg::ST_DIV_START;
                end
            end
            rubn_pkg::ST_DIV_START:
            begin
                if (ext_zero)
                begin
                    deg_next   = 1'b1;
                    axis_write = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = rubn_pkg::ST_DIV_WAIT;
                end
            end
            rubn_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    axis_val   = div_quot;
                    axis_write = 1'b1;
                end
            end
            rubn_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_x_next   = res_x_reg;
                    out_y_next   = res_y_reg;
                    out_z_next   = res_z_reg;
                    out_deg_next = deg_reg;
                    m_valid_next = 1'b1;
                    state_next   = rubn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rubn_pkg::ST_IDLE;
            end
        endcase

        // store this axis and move on
        if (axis_write)
        begin
            case (axis_reg)
                rubn_pkg::AX_X: res_x_next = axis_val;
                rubn_pkg::AX_Y: res_y_next = axis_val;
                rubn_pkg::AX_Z: res_z_next = axis_val;
                default:        res_x_next = res_x_reg;
            endcase
            if (last_axis)
            begin
                state_next = rubn_pkg::ST_DONE;
            end
            else
            begin
                axis_next  = rubn_pkg::axis_t'(axis_reg + 2'd1);
                state_next = rubn_pkg::ST_DIV_START;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_z_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_deg_reg;

`ifndef SYNTH
    a_rot_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rot_done |-> state_reg == rubn_pkg::ST_ROT)
        else $error("rotation finished outside the rotate state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == rubn_pkg::ST_DIV_WAIT)
        else $error("division finished outside the wait state");

    a_box_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (min_x_reg > max_x_reg) == (min_z_reg > max_z_reg))
        else $error("box axes disagree on emptiness");
`endif

endmodule

/* rtl/rubn_rot.sv */
// z-axis rotation on one shared signed multiplier, four products in turn
// depends on rubn_pkg
module rubn_rot #(
    parameter int COORD_WIDTH = rubn_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC   = rubn_pkg::TRIG_FRAC_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [rubn_pkg::TRIG_WIDTH-1:0]  cos_angle,
    input  logic signed [rubn_pkg::TRIG_WIDTH-1:0]  sin_angle,
    input  logic signed [COORD_WIDTH-1:0]           x,
    input  logic signed [COORD_WIDTH-1:0]           y,
    output logic                                    done,
    output logic signed [COORD_WIDTH-1:0]           rx,
    output logic signed [COORD_WIDTH-1:0]           ry
);

    localparam int PW = rubn_pkg::TRIG_WIDTH + COORD_WIDTH;
    localparam int SW = PW + 1;

    rubn_pkg::rot_st_t st_reg, st_next;

    logic signed [PW-1:0]                   prod_reg, prod_next;
    logic signed [PW-1:0]                   acc_reg, acc_next;
    logic signed [COORD_WIDTH-1:0]          rx_reg, rx_next;
    logic signed [COORD_WIDTH-1:0]          ry_reg, ry_next;
    logic signed [rubn_pkg::TRIG_WIDTH-1:0] mul_a;
    logic signed [COORD_WIDTH-1:0]          mul_b;
    logic signed [SW-1:0]                   sum;
    logic signed [SW-1:0]                   shifted;
    logic [SW-COORD_WIDTH:0]                hi;
    logic signed [COORD_WIDTH-1:0]          sat_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= rubn_pkg::ROT_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
    end

    // saturate the floor-shifted sum to the coordinate width
    always_comb
    begin
        shifted = sum >>> TRIG_FRAC;
        hi      = shifted[SW-1:COORD_WIDTH-1];
        if (hi == '0 || hi == '1)
        begin
            sat_val = shifted[COORD_WIDTH-1:0];
        end
        else if (shifted[SW-1])
        begin
            sat_val = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        mul_a     = cos_angle;
        mul_b     = x;
        sum       = {acc_reg[PW-1], acc_reg} - {prod_reg[PW-1], prod_reg};
        done      = 1'b0;
        case (st_reg)
            rubn_pkg::ROT_IDLE:
            begin
                if (start)
                begin
                    st_next = rubn_pkg::ROT_CX;
                end
            end
            rubn_pkg::ROT_CX:
            begin
                prod_next = mul_a * mul_b;
                st_next   = rubn_pkg::ROT_SY;
            end
            rubn_pkg::ROT_SY:
            begin
                mul_a     = sin_angle;
                mul_b     = y;
                acc_next  = prod_reg;
                prod_next = mul_a * mul_b;
                st_next   = rubn_pkg::ROT_SX;
            end
            rubn_pkg::ROT_SX:
            begin
                mul_a     = sin_angle;
                rx_next   = sat_val;
                prod_next = mul_a * mul_b;
                st_next   = rubn_pkg::ROT_CY;
            end
            rubn_pkg::ROT_CY:
            begin
                mul_b     = y;
                acc_next  = prod_reg;
                prod_next = mul_a * mul_b;
                st_next   = rubn_pkg::ROT_FIN;
            end
            rubn_pkg::ROT_FIN:
            begin
                sum     = {acc_reg[PW-1], acc_reg} + {prod_reg[PW-1], prod_reg};
                ry_next = sat_val;
                done    = 1'b1;
                st_next = rubn_pkg::ROT_IDLE;
            end
            default:
            begin
                st_next = rubn_pkg::ROT_IDLE;
            end
        endcase
    end

    assign rx = rx_reg;
    assign ry = ry_reg;

endmodule

/* rtl/rubn_div.sv */
// radix-2 restoring divider: signed offset times 2^frac over a positive extent,
// truncated toward zero and saturated; depends on rubn_pkg
module rubn_div #(
    parameter int COORD_WIDTH = rubn_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC  = rubn_pkg::COORD_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH:0]   numer,
    input  logic [COORD_WIDTH-1:0]        denom,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] quot
);

    localparam int NW    = COORD_WIDTH + 1 + COORD_FRAC;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]          nq_reg, nq_next;
    logic [COORD_WIDTH-1:0] rem_reg, rem_next;
    logic [COORD_WIDTH-1:0] den_reg, den_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COORD_WIDTH-1:0] quot_reg, quot_next;
    logic [COORD_WIDTH:0]   mag;
    logic [COORD_WIDTH:0]   trial;
    logic [COORD_WIDTH:0]   diff;
    logic                   ge;
    logic [NW-1:0]          limit;
    logic [NW-1:0]          qc;
    logic [COORD_WIDTH-1:0] q_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        mag   = numer[COORD_WIDTH] ? (~numer + 1'b1) : numer;
        trial = {rem_reg, nq_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
        limit = {{(NW-COORD_WIDTH){1'b0}},
                 neg_reg ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                         : {1'b0, {(COORD_WIDTH-1){1'b1}}}};
        qc    = (nq_reg > limit) ? limit : nq_reg;
        q_low = qc[COORD_WIDTH-1:0];

        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;

        if (start)
        begin
            nq_next   = {mag, {COORD_FRAC{1'b0}}};
            rem_next  = '0;
            den_next  = denom;
            neg_next  = numer[COORD_WIDTH];
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                quot_next = neg_reg ? (~q_low + 1'b1) : q_low;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
                nq_next  = {nq_reg[NW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
`endif

endmodule

/* sim/rotate_and_unit_box_normalize_unit_test.sv */
// self-checking bench for the rotate and unit-box normalise unit: drives point transfers,
// predicts every normalised result on its own and compares each output transfer in order
// depends on rubn_pkg and rotate_and_unit_box_normalize_unit
module rotate_and_unit_box_normalize_unit_test;

    localparam int CW = rubn_pkg::COORD_WIDTH_DEF;
    localparam int CF = rubn_pkg::COORD_FRAC_DEF;
    localparam int TF = rubn_pkg::TRIG_FRAC_DEF;
    localparam int TW = rubn_pkg::TRIG_WIDTH;
    localparam int DW = ((3*CW+7)/8)*8;

    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 1850;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam longint COORD_MAX_L = longint'(COORD_MAX);
    localparam longint COORD_MIN_L = longint'(COORD_MIN);

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 deg;
    } norm_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [DW-1:0]                  s_tdata = '0;
    logic [rubn_pkg::CMD_WIDTH-1:0] s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [DW-1:0]                  m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_we = 1'b0;
    logic [0:0]                     cfg_index = '0;
    logic [TW-1:0]                  cfg_data = '0;

    // predictor state: box and angle as the block keeps them
    logic signed [CW-1:0] box_lo_x, box_lo_y, box_lo_z;
    logic signed [CW-1:0] box_hi_x, box_hi_y, box_hi_z;
    logic signed [TW-1:0] ang_cos, ang_sin;

    norm_result_t pending_norm[$];
    int           mismatch_count = 0;
    int           sent_count = 0;
    int           idle_cycles = 0;
    int           hold_left = 0;
    int           rcv_gap = 0;
    bit           hold_req = 1'b0;
    bit           steady = 1'b0;

    rotate_and_unit_box_normalize_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic signed [CW-1:0] sat_coord(longint v);
        if (v > COORD_MAX_L)
            return COORD_MAX;
        if (v < COORD_MIN_L)
            return COORD_MIN;
        return v[CW-1:0];
    endfunction

    // offset scaled to the unit box, truncated toward zero and saturated
    function automatic logic signed [CW-1:0] unit_div(longint d, longint e);
        longint mag;
        longint lim;
        longint q;
        mag = (d < 0) ? -d : d;
        lim = (d < 0) ? COORD_MAX_L + 1 : COORD_MAX_L;
        q = (mag <<< CF) / e;
        if (q > lim)
            q = lim;
        if (d < 0)
            q = -q;
        return q[CW-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(int span);
        case (span)
            0: return $urandom;
            1: return int'($urandom_range(0, 2097152)) - 1048576;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return COORD_MAX - 1;
                endcase
            end
            default: return $signed($urandom) >>> 3;
        endcase
    endfunction

    function automatic logic signed [TW-1:0] pick_angle();
        int a;
        case ($urandom_range(0, 7))
            0: a = 16384;
            1: a = -16384;
            2: a = 0;
            default: a = int'($urandom_range(0, 32768)) - 16384;
        endcase
        return TW'(a);
    endfunction

    task automatic empty_box();
        box_lo_x = COORD_MAX;
        box_lo_y = COORD_MAX;
        box_lo_z = COORD_MAX;
        box_hi_x = COORD_MIN;
        box_hi_y = COORD_MIN;
        box_hi_z = COORD_MIN;
    endtask

    task automatic predict_point(rubn_pkg::cmd_t cmd, logic signed [CW-1:0] x,
                                 logic signed [CW-1:0] y, logic signed [CW-1:0] z);
        longint               cx, sy, sx, cy;
        logic signed [CW-1:0] rx, ry;
        norm_result_t         r;
        cx = longint'(ang_cos) * longint'(x);
        sy = longint'(ang_sin) * longint'(y);
        sx = longint'(ang_sin) * longint'(x);
        cy = longint'(ang_cos) * longint'(y);
        rx = sat_coord((cx - sy) >>> TF);
        ry = sat_coord((sx + cy) >>> TF);
        r = '{x: '0, y: '0, z: '0, deg: 1'b0};
        case (cmd)
            rubn_pkg::CMD_CLEAR:
                empty_box();
            rubn_pkg::CMD_MEASURE:
            begin
                if (rx < box_lo_x) box_lo_x = rx;
                if (ry < box_lo_y) box_lo_y = ry;
                if (z < box_lo_z)  box_lo_z = z;
                if (rx > box_hi_x) box_hi_x = rx;
                if (ry > box_hi_y) box_hi_y = ry;
                if (z > box_hi_z)  box_hi_z = z;
            end
            rubn_pkg::CMD_NORMALIZE:
            begin
                if (box_lo_x > box_hi_x)
                    r.deg = 1'b1;
                else
                begin
                    if (box_hi_x == box_lo_x)
                        r.deg = 1'b1;
                    else
                        r.x = unit_div(longint'(rx) - longint'(box_lo_x),
                                       longint'(box_hi_x) - longint'(box_lo_x));
                    if (box_hi_y == box_lo_y)
                        r.deg = 1'b1;
                    else
                        r.y = unit_div(longint'(ry) - longint'(box_lo_y),
                                       longint'(box_hi_y) - longint'(box_lo_y));
                    if (box_hi_z == box_lo_z)
                        r.deg = 1'b1;
                    else
                        r.z = unit_div(longint'(z) - longint'(box_lo_z),
                                       longint'(box_hi_z) - longint'(box_lo_z));
                end
                pending_norm.push_back(r);
            end
            default: ;
        endcase
    endtask

    // one input transfer; valid stays high into the next call unless a gap follows
    task automatic send_point(rubn_pkg::cmd_t cmd, logic signed [CW-1:0] x,
                              logic signed [CW-1:0] y, logic signed [CW-1:0] z);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        predict_point(cmd, x, y, z);
        if (cmd != rubn_pkg::CMD_NONE)
            sent_count++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(rubn_pkg::cmd_t cmd, int span);
        send_point(cmd, pick_coord(span), pick_coord(span), pick_coord(span));
    endtask

    // stop sending, let every result drain and the block go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_norm.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_angle(logic signed [TW-1:0] c, logic signed [TW-1:0] s);
        cfg_we    <= 1'b1;
        cfg_index <= rubn_pkg::REG_COS;
        cfg_data  <= c;
        @(posedge clk);
        ang_cos = c;
        cfg_index <= rubn_pkg::REG_SIN;
        cfg_data  <= s;
        @(posedge clk);
        ang_sin = s;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic signed [CW-1:0] want, logic signed [CW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        norm_result_t want;
        if (pending_norm.size() == 0)
        begin
            $display("%0t: unexpected result, got %0d %0d %0d degenerate %0d", $time,
                     $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
                     $signed(m_tdata[3*CW-1:2*CW]), m_tuser[0]);
            mismatch_count++;
        end
        else
        begin
            want = pending_norm.pop_front();
            check_field("x_norm", want.x, m_tdata[CW-1:0]);
            check_field("y_norm", want.y, m_tdata[2*CW-1:CW]);
            check_field("z_norm", want.z, m_tdata[3*CW-1:2*CW]);
            check_field("degenerate", CW'(want.deg), CW'(m_tuser[0]));
        end
    endtask

    // output side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rcv_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_random(rubn_pkg::CMD_NORMALIZE, 0);
        send_point(rubn_pkg::CMD_NONE, COORD_MAX, COORD_MIN, 0);
        send_random(rubn_pkg::CMD_NORMALIZE, 2);
    endtask

    task automatic test_directed_extremes();
        send_point(rubn_pkg::CMD_MEASURE, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(rubn_pkg::CMD_MEASURE, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(rubn_pkg::CMD_NORMALIZE, 0, 0, 0);
        send_point(rubn_pkg::CMD_NORMALIZE, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(rubn_pkg::CMD_NORMALIZE, COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(rubn_pkg::CMD_NORMALIZE, -1, 1, COORD_MAX - 1);
        send_point(rubn_pkg::CMD_NONE, 7, 7, 7);
        send_point(rubn_pkg::CMD_NORMALIZE, 7, 7, 7);
        // single point: zero extent on every axis
        send_point(rubn_pkg::CMD_CLEAR, -1, -1, -1);
        send_point(rubn_pkg::CMD_MEASURE, 5 <<< 16, -(3 <<< 16), 7);
        send_point(rubn_pkg::CMD_NORMALIZE, 5 <<< 16, -(3 <<< 16), 7);
        // flat in z only
        send_point(rubn_pkg::CMD_MEASURE, -(2 <<< 16), 9 <<< 16, 7);
        send_point(rubn_pkg::CMD_NORMALIZE, 0, 0, 7);
        // tiny box, points far outside saturate both ways
        send_point(rubn_pkg::CMD_CLEAR, 0, 0, 0);
        send_point(rubn_pkg::CMD_MEASURE, 0, 0, 0);
        send_point(rubn_pkg::CMD_MEASURE, 1, 1, 1);
        send_point(rubn_pkg::CMD_NORMALIZE, COORD_MAX, COORD_MIN, COORD_MAX);
        send_point(rubn_pkg::CMD_NORMALIZE, COORD_MIN, COORD_MAX, COORD_MIN);
        // cleared box is empty again
        send_point(rubn_pkg::CMD_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(rubn_pkg::CMD_NORMALIZE, 1, 2, 3);
    endtask

    task automatic test_angle_sweep();
        int                   cos_list[8] = '{16384, -16384, 0, 0, 16384, -16384, 11585, -11585};
        int                   sin_list[8] = '{0, 0, 16384, -16384, 16384, -16384, 11585, 11585};
        logic signed [CW-1:0] px, py, pz;
        for (int i = 0; i < 8; i++)
        begin
            settle_block();
            set_angle(TW'(cos_list[i]), TW'(sin_list[i]));
            send_random(rubn_pkg::CMD_CLEAR, 0);
            send_random(rubn_pkg::CMD_MEASURE, 2);
            px = pick_coord(i % 4);
            py = pick_coord(i % 4);
            pz = pick_coord(i % 4);
            send_point(rubn_pkg::CMD_MEASURE, px, py, pz);
            send_random(rubn_pkg::CMD_MEASURE, i % 4);
            send_point(rubn_pkg::CMD_MEASURE, COORD_MIN, COORD_MAX, 0);
            send_point(rubn_pkg::CMD_NORMALIZE, px, py, pz);
            send_random(rubn_pkg::CMD_NORMALIZE, i % 4);
            send_random(rubn_pkg::CMD_NORMALIZE, 2);
        end
    endtask

    task automatic test_output_hold();
        settle_block();
        steady = 1'b1;
        send_random(rubn_pkg::CMD_CLEAR, 1);
        repeat (3) send_random(rubn_pkg::CMD_MEASURE, 1);
        hold_req = 1'b1;
        repeat (8) send_random(rubn_pkg::CMD_NORMALIZE, 1);
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (5) send_random(rubn_pkg::CMD_NORMALIZE, 3);
        s_tvalid <= 1'b0;
        while (pending_norm.size() != 0)
            @(posedge clk);
        repeat (5) send_random(rubn_pkg::CMD_NORMALIZE, 3);
    endtask

    task automatic run_box_sequence();
        logic signed [CW-1:0] px[8], py[8], pz[8];
        int                   span, n, m, k;
        bit                   flat_z;
        span   = $urandom_range(0, 3);
        n      = $urandom_range(1, 8);
        flat_z = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0)
            send_random(rubn_pkg::CMD_CLEAR, 0);
        for (int i = 0; i < n; i++)
        begin
            px[i] = pick_coord(span);
            py[i] = pick_coord(span);
            pz[i] = flat_z && i > 0 ? pz[0] : pick_coord(span);
            send_point(rubn_pkg::CMD_MEASURE, px[i], py[i], pz[i]);
        end
        m = $urandom_range(1, 6);
        for (int j = 0; j < m; j++)
        begin
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 3))
                0, 1: send_point(rubn_pkg::CMD_NORMALIZE, px[k], py[k], pz[k]);
                2: send_random(rubn_pkg::CMD_NORMALIZE, span);
                default: send_random(rubn_pkg::CMD_NORMALIZE, $urandom_range(0, 3));
            endcase
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 5))
            send_random(rubn_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 3));
    endtask

    task automatic test_random_traffic();
        int next_cfg;
        next_cfg = sent_count;
        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count >= next_cfg)
            begin
                settle_block();
                set_angle(pick_angle(), pick_angle());
                next_cfg = sent_count + 150;
            end
            steady = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 78)
                run_box_sequence();
            else
                run_noise();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        ang_cos = rubn_pkg::COS_RESET;
        ang_sin = rubn_pkg::SIN_RESET;
        empty_box();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_extremes();
        test_angle_sweep();
        test_output_hold();
        test_drain_pause();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_norm.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
